[design/eq_pkg.sv]
package eq_pkg;

    localparam int ANG_W   = 16;
    localparam int QUAT_W  = 16;
    localparam int CW      = 24;
    localparam int STEPS   = 16;
    localparam int PW      = 2 * CW;
    localparam int TW      = 3 * CW;
    localparam int SW      = TW + 1;
    localparam int RND_SH  = 46;
    localparam int LANE_LAT  = STEPS + 2;
    localparam int MERGE_LAT = 5;
    localparam int LAT       = LANE_LAT + MERGE_LAT;

    typedef logic signed [ANG_W-1:0]  t_ang;
    typedef logic signed [QUAT_W-1:0] t_quat;
    typedef logic signed [CW-1:0]     t_cval;
    typedef logic signed [PW-1:0]     t_pair;
    typedef logic signed [TW-1:0]     t_trip;
    typedef logic signed [SW-1:0]     t_sum;

    typedef struct packed {
        logic en;
    } t_ctrl;

    localparam t_cval HALF_PI = 24'sd1647099;
    localparam t_cval ANG_PI  = 24'sd3294199;
    localparam t_cval GAIN    = 24'sd636751;

    localparam t_cval ATAN_TAB [STEPS] = '{
        24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396,
        24'sd65451,  24'sd32757,  24'sd16383,  24'sd8192,
        24'sd4096,   24'sd2048,   24'sd1024,   24'sd512,
        24'sd256,    24'sd128,    24'sd64,     24'sd32
    };

endpackage

[design/eq_if.sv]
interface eq_ang_if;
    logic               valid;
    logic               ready;
    eq_pkg::t_ang       yaw_angle;
    eq_pkg::t_ang       pitch_angle;
    eq_pkg::t_ang       roll_angle;

    modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
    modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

interface eq_quat_if;
    logic               valid;
    logic               ready;
    eq_pkg::t_quat      quat_w;
    eq_pkg::t_quat      quat_x;
    eq_pkg::t_quat      quat_y;
    eq_pkg::t_quat      quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

[design/eq_cordic.sv]
module eq_cordic (
    input  logic                 i_clk,
    input  eq_pkg::t_ctrl        i_ctrl,
    input  eq_pkg::t_ang         i_angle,
    output eq_pkg::t_cval        o_sin,
    output eq_pkg::t_cval        o_cos
);

    eq_pkg::t_cval r_x    [eq_pkg::STEPS+1];
    eq_pkg::t_cval r_y    [eq_pkg::STEPS+1];
    eq_pkg::t_cval r_z    [eq_pkg::STEPS+1];
    logic          r_flip [eq_pkg::STEPS+1];
    eq_pkg::t_cval r_sin;
    eq_pkg::t_cval r_cos;
    eq_pkg::t_cval n_z;
    logic          n_flip;

    // half angle at 20 fractional bits and quadrant fold
    always_comb begin
        n_z    = eq_pkg::t_cval'({{2{i_angle[eq_pkg::ANG_W-1]}}, i_angle, 6'b0});
        n_flip = 1'b0;
        if (n_z > eq_pkg::HALF_PI) begin
            n_z    = n_z - eq_pkg::ANG_PI;
            n_flip = 1'b1;
        end else if (n_z < -eq_pkg::HALF_PI) begin
            n_z    = n_z + eq_pkg::ANG_PI;
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_x[0]    <= eq_pkg::GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= n_z;
            r_flip[0] <= n_flip;
        end
    end

    for (genvar i = 0; i < eq_pkg::STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_ctrl.en) begin
                r_flip[i+1] <= r_flip[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - eq_pkg::ATAN_TAB[i];
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + eq_pkg::ATAN_TAB[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_sin <= r_flip[eq_pkg::STEPS] ? -r_y[eq_pkg::STEPS] : r_y[eq_pkg::STEPS];
            r_cos <= r_flip[eq_pkg::STEPS] ? -r_x[eq_pkg::STEPS] : r_x[eq_pkg::STEPS];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

[design/eq_merge.sv]
module eq_merge (
    input  logic            i_clk,
    input  eq_pkg::t_ctrl   i_ctrl,
    input  eq_pkg::t_cval   i_sy,
    input  eq_pkg::t_cval   i_cy,
    input  eq_pkg::t_cval   i_sp,
    input  eq_pkg::t_cval   i_cp,
    input  eq_pkg::t_cval   i_sr,
    input  eq_pkg::t_cval   i_cr,
    output eq_pkg::t_quat   o_w,
    output eq_pkg::t_quat   o_x,
    output eq_pkg::t_quat   o_y,
    output eq_pkg::t_quat   o_z
);

    localparam int HW = eq_pkg::PW - eq_pkg::CW;

    eq_pkg::t_pair r_cycp, r_sysp, r_sycp, r_cysp;
    eq_pkg::t_cval r_sr1, r_cr1;
    eq_pkg::t_pair n_a   [8];
    eq_pkg::t_cval n_c   [8];
    logic signed [eq_pkg::PW-1:0] r_hi [8];
    logic signed [eq_pkg::PW:0]   r_lo [8];
    eq_pkg::t_trip r_t   [8];
    eq_pkg::t_sum  r_s   [4];
    eq_pkg::t_quat r_q   [4];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_cycp <= i_cy * i_cp;
            r_sysp <= i_sy * i_sp;
            r_sycp <= i_sy * i_cp;
            r_cysp <= i_cy * i_sp;
            r_sr1  <= i_sr;
            r_cr1  <= i_cr;
        end
    end

    always_comb begin
        n_a[0] = r_cycp; n_c[0] = r_cr1;
        n_a[1] = r_sysp; n_c[1] = r_sr1;
        n_a[2] = r_cycp; n_c[2] = r_sr1;
        n_a[3] = r_sysp; n_c[3] = r_cr1;
        n_a[4] = r_sycp; n_c[4] = r_sr1;
        n_a[5] = r_cysp; n_c[5] = r_cr1;
        n_a[6] = r_sycp; n_c[6] = r_cr1;
        n_a[7] = r_cysp; n_c[7] = r_sr1;
    end

    // each 48 by 24 product split in two partial products
    for (genvar k = 0; k < 8; k++) begin : g_prod
        logic signed [HW-1:0]        w_ah;
        logic signed [eq_pkg::CW:0]  w_al;
        assign w_ah = n_a[k][eq_pkg::PW-1:eq_pkg::CW];
        assign w_al = {1'b0, n_a[k][eq_pkg::CW-1:0]};
        always_ff @(posedge i_clk) begin
            if (i_ctrl.en) begin
                r_hi[k] <= w_ah * n_c[k];
                r_lo[k] <= w_al * n_c[k];
                r_t[k]  <= (eq_pkg::t_trip'(r_hi[k]) <<< eq_pkg::CW)
                           + eq_pkg::t_trip'(r_lo[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_s[0] <= eq_pkg::t_sum'(r_t[0]) + eq_pkg::t_sum'(r_t[1]);
            r_s[1] <= eq_pkg::t_sum'(r_t[2]) - eq_pkg::t_sum'(r_t[3]);
            r_s[2] <= eq_pkg::t_sum'(r_t[4]) + eq_pkg::t_sum'(r_t[5]);
            r_s[3] <= eq_pkg::t_sum'(r_t[6]) - eq_pkg::t_sum'(r_t[7]);
        end
    end

    // round half up to 14 fractional bits, then saturate
    for (genvar j = 0; j < 4; j++) begin : g_out
        eq_pkg::t_sum w_r;
        logic signed [eq_pkg::SW-eq_pkg::RND_SH-1:0] w_sh;
        assign w_r  = r_s[j] + (eq_pkg::t_sum'(1) <<< (eq_pkg::RND_SH - 1));
        assign w_sh = w_r[eq_pkg::SW-1:eq_pkg::RND_SH];
        always_ff @(posedge i_clk) begin
            if (i_ctrl.en) begin
                if (w_sh > 32767) begin
                    r_q[j] <= 16'sh7fff;
                end else if (w_sh < -32768) begin
                    r_q[j] <= 16'sh8000;
                end else begin
                    r_q[j] <= w_sh[eq_pkg::QUAT_W-1:0];
                end
            end
        end
    end

    assign o_w = r_q[0];
    assign o_x = r_q[1];
    assign o_y = r_q[2];
    assign o_z = r_q[3];

endmodule

[design/euler_to_quaternion.sv]
// throughput: one item per cycle while the output is not stalled
// three cordic lanes of 16 steps plus a 5 stage product merge
// a stalled output holds the whole pipeline; ready = output empty or taken
// synchronous active-low reset clears the valid chain only
module euler_to_quaternion (
    input  logic        i_clk,
    input  logic        i_rst_n,
    eq_ang_if.sink      i_ang,
    eq_quat_if.source   o_quat
);

    eq_pkg::t_ctrl w_ctrl;
    eq_pkg::t_cval w_sy, w_cy, w_sp, w_cp, w_sr, w_cr;
    logic [eq_pkg::LAT-1:0] r_vld;

    assign w_ctrl.en   = o_quat.ready || !r_vld[eq_pkg::LAT-1];
    assign i_ang.ready = w_ctrl.en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ctrl.en) begin
            r_vld <= {r_vld[eq_pkg::LAT-2:0], i_ang.valid};
        end
    end

    eq_cordic u_yaw (
        .i_clk(i_clk), .i_ctrl(w_ctrl), .i_angle(i_ang.yaw_angle),
        .o_sin(w_sy), .o_cos(w_cy)
    );

    eq_cordic u_pitch (
        .i_clk(i_clk), .i_ctrl(w_ctrl), .i_angle(i_ang.pitch_angle),
        .o_sin(w_sp), .o_cos(w_cp)
    );

    eq_cordic u_roll (
        .i_clk(i_clk), .i_ctrl(w_ctrl), .i_angle(i_ang.roll_angle),
        .o_sin(w_sr), .o_cos(w_cr)
    );

    eq_merge u_merge (
        .i_clk(i_clk), .i_ctrl(w_ctrl),
        .i_sy(w_sy), .i_cy(w_cy), .i_sp(w_sp), .i_cp(w_cp), .i_sr(w_sr), .i_cr(w_cr),
        .o_w(o_quat.quat_w), .o_x(o_quat.quat_x), .o_y(o_quat.quat_y), .o_z(o_quat.quat_z)
    );

    assign o_quat.valid = r_vld[eq_pkg::LAT-1];

endmodule

[design/eq_check.sv]
module eq_check (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input eq_pkg::t_quat i_w,
    input eq_pkg::t_quat i_x,
    input eq_pkg::t_quat i_y,
    input eq_pkg::t_quat i_z
);

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_ready: assert property (@(posedge i_clk)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled with room at the output");

    a_no_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input transfer during output stall");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_w) && $stable(i_x)
            && $stable(i_y) && $stable(i_z)))
        else $error("stalled result changed");

endmodule

bind euler_to_quaternion eq_check u_eq_check (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_ang.valid), .i_in_ready(i_ang.ready),
    .i_out_valid(o_quat.valid), .i_out_ready(o_quat.ready),
    .i_w(o_quat.quat_w), .i_x(o_quat.quat_x), .i_y(o_quat.quat_y), .i_z(o_quat.quat_z)
);

[verif/euler_to_quaternion_test.sv]
`timescale 1ns / 1ps

module euler_to_quaternion_test;

    typedef struct {
        eq_pkg::t_quat w;
        eq_pkg::t_quat x;
        eq_pkg::t_quat y;
        eq_pkg::t_quat z;
    } t_quat_exp;

    logic i_clk;
    logic i_rst_n;
    eq_ang_if  ang_ch ();
    eq_quat_if quat_ch ();

    euler_to_quaternion i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ang   (ang_ch.sink),
        .o_quat  (quat_ch.source)
    );

    t_quat_exp quat_exp_q[$];
    int        n_errors;
    bit        no_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // half-angle sine and cosine, 20 fractional bits
    function automatic void half_sin_cos(input eq_pkg::t_ang ang,
                                         output longint s, output longint c);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = longint'(ang) * 64;
        x = eq_pkg::GAIN;
        y = 0;
        flip = 1'b0;
        if (z > eq_pkg::HALF_PI) begin
            z = z - eq_pkg::ANG_PI;
            flip = 1'b1;
        end else if (z < -longint'(eq_pkg::HALF_PI)) begin
            z = z + eq_pkg::ANG_PI;
            flip = 1'b1;
        end
        for (int i = 0; i < eq_pkg::STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - eq_pkg::ATAN_TAB[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + eq_pkg::ATAN_TAB[i];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic eq_pkg::t_quat round_sat(input logic signed [127:0] sum);
        logic signed [127:0] r;
        r = (sum + (128'sd1 <<< 45)) >>> eq_pkg::RND_SH;
        if (r > 32767) return 16'sh7fff;
        if (r < -32768) return 16'sh8000;
        return eq_pkg::t_quat'(r[15:0]);
    endfunction

    function automatic t_quat_exp zyx_quat(input eq_pkg::t_ang yaw, input eq_pkg::t_ang pitch,
                                           input eq_pkg::t_ang roll);
        longint sy, cy, sp, cp, sr, cr;
        logic signed [127:0] a, b, c2, d, e, f;
        t_quat_exp q;
        half_sin_cos(yaw, sy, cy);
        half_sin_cos(pitch, sp, cp);
        half_sin_cos(roll, sr, cr);
        a = 128'(cy) * 128'(cp);
        b = 128'(sy) * 128'(sp);
        c2 = 128'(sy) * 128'(cp);
        d = 128'(cy) * 128'(sp);
        e = 128'(cr);
        f = 128'(sr);
        q.w = round_sat(a * e + b * f);
        q.x = round_sat(a * f - b * e);
        q.y = round_sat(c2 * f + d * e);
        q.z = round_sat(c2 * e - d * f);
        return q;
    endfunction

    task automatic send_angles(input eq_pkg::t_ang yaw, input eq_pkg::t_ang pitch,
                               input eq_pkg::t_ang roll);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            ang_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ang_ch.valid       <= 1'b1;
        ang_ch.yaw_angle   <= yaw;
        ang_ch.pitch_angle <= pitch;
        ang_ch.roll_angle  <= roll;
        @(posedge i_clk);
        while (!ang_ch.ready) @(posedge i_clk);
        quat_exp_q.push_back(zyx_quat(yaw, pitch, roll));
    endtask

    task automatic drop_valid();
        ang_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        drop_valid();
        while (quat_exp_q.size() != 0) @(posedge i_clk);
    endtask

    // extremes, zero, quarter and half turns
    task automatic test_directed();
        eq_pkg::t_ang v[8];
        v = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff,
              16'sd12868, -16'sd12868, 16'sd25736};
        for (int i = 0; i < 8; i++) send_angles(v[i], v[i], v[i]);
        for (int i = 0; i < 8; i++) send_angles(v[i], v[(i + 3) % 8], v[(i + 5) % 8]);
        send_angles(16'sh7fff, 16'sh8000, 16'sh0000);
        send_angles(16'sh8000, 16'sh7fff, 16'sh7fff);
        send_angles(16'sh5555, 16'shaaaa, 16'sh5555);
        send_angles(16'shaaaa, 16'sh5555, 16'shaaaa);
    endtask

    task automatic test_pause_drain();
        wait_drained();
        send_angles(16'sd100, -16'sd200, 16'sd300);
        wait_drained();
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) begin
            send_angles(eq_pkg::t_ang'($urandom), eq_pkg::t_ang'($urandom),
                        eq_pkg::t_ang'($urandom));
        end
    endtask

    task automatic test_near_pi();
        // half angles around the range reduction points
        for (int i = 0; i < 100; i++) begin
            send_angles(eq_pkg::t_ang'(16'sd25736 + $urandom_range(0, 16) - 8),
                        eq_pkg::t_ang'(-16'sd25736 + $urandom_range(0, 16) - 8),
                        eq_pkg::t_ang'($urandom));
        end
    endtask

    // result checker
    initial begin
        t_quat_exp e;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && quat_ch.valid && quat_ch.ready) begin
                if (quat_exp_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) $display("unexpected transfer at %0t", $realtime);
                end else begin
                    e = quat_exp_q.pop_front();
                    if (e.w !== quat_ch.quat_w || e.x !== quat_ch.quat_x ||
                        e.y !== quat_ch.quat_y || e.z !== quat_ch.quat_z) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                     e.w, e.x, e.y, e.z, quat_ch.quat_w, quat_ch.quat_x,
                                     quat_ch.quat_y, quat_ch.quat_z);
                    end
                end
            end
        end
    end

    // output backpressure
    initial begin
        int gap;
        quat_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!no_idle && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 5);
                quat_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            quat_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        n_errors = 0;
        no_idle = 1'b0;
        i_rst_n <= 1'b0;
        ang_ch.valid <= 1'b0;
        ang_ch.yaw_angle <= '0;
        ang_ch.pitch_angle <= '0;
        ang_ch.roll_angle <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_pause_drain();
        test_near_pi();
        test_random(1000);
        no_idle = 1'b1;
        test_random(300);
        wait_drained();
        repeat (eq_pkg::LAT + 5) @(posedge i_clk);
        if (n_errors == 0 && quat_exp_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
design/eq_pkg.sv
design/eq_if.sv
design/eq_cordic.sv
design/eq_merge.sv
design/euler_to_quaternion.sv
design/eq_check.sv
verif/euler_to_quaternion_test.sv
